@@ rtl/msh_pkg.sv @@
// Shared types and constants for the MurmurHash64A stream hash block.
package msh_pkg;

   localparam logic [63:0] MIX_MUL = 64'hc6a4a7935bd1e995;
   localparam int unsigned MIX_SHIFT = 47;
   localparam logic [63:0] SEED_RESET = 64'h0000_0000_41C6_4E6D;
   localparam int unsigned MSH_QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,
      KIND_PART = 2'd1,
      KIND_FULL = 2'd2
   } kind_type;

   typedef struct packed {
      logic        first;
      logic        last;
      kind_type    kind;
      logic [63:0] word;
      logic [31:0] len;
   } msh_item_type;

endpackage

@@ rtl/murmur64a_stream_hash_top.sv @@
// MurmurHash64A stream hash: 64-bit little-endian message words in, one 64-bit
// hash out per message. The first request of a message carries the total byte
// length; the last request marks the end and yields the hash in rsp_hash_value.
// Requests enter a short queue and are taken by the hash engine one at a time.
// All multiplies by the mix constant go through one shared 32x32 multiplier,
// three partial products per 64-bit multiply. A full word takes 3 multiplies,
// a partial word 1, the first word of a message adds 1 multiply for the length
// term, and the last word adds 1 multiply and a step that loads the result
// register. The seed is written through csr_wr_en/csr_wr_data and applies to
// messages started afterwards.
module murmur64a_stream_hash_top #(
   parameter int unsigned QueueDepth = msh_pkg::MSH_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_data_word,
   input  logic [3:0]  req_valid_bytes,
   input  logic        req_last_word,
   input  logic [31:0] req_message_length,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_hash_value,
   input  logic        csr_wr_en,
   input  logic [63:0] csr_wr_data
);
   import msh_pkg::*;

   logic         q_push, q_push_ready;
   msh_item_type q_push_item;
   logic         q_pop, q_pop_valid;
   msh_item_type q_pop_item;

   msh_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_word      (req_data_word),
      .req_valid_bytes    (req_valid_bytes),
      .req_last_word      (req_last_word),
      .req_message_length (req_message_length),
      .q_ready            (q_push_ready),
      .q_push             (q_push),
      .q_item             (q_push_item)
   );

   msh_fifo #(
      .Depth (QueueDepth)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_item  (q_push_item),
      .push_ready (q_push_ready),
      .pop        (q_pop),
      .pop_valid  (q_pop_valid),
      .pop_item   (q_pop_item)
   );

   msh_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_pop_valid),
      .q_item         (q_pop_item),
      .q_pop          (q_pop),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hash_value (rsp_hash_value)
   );

endmodule

@@ rtl/msh_front.sv @@
// Front end: accepts requests, tracks message start and classifies each word.
module msh_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [63:0]           req_data_word,
   input  logic [3:0]            req_valid_bytes,
   input  logic                  req_last_word,
   input  logic [31:0]           req_message_length,
   input  logic                  q_ready,
   output logic                  q_push,
   output msh_pkg::msh_item_type q_item
);
   import msh_pkg::*;

   logic       in_msg_ff;
   logic       in_msg_in;
   logic [7:0] byte_keep;

   assign req_ready = q_ready;
   assign q_push    = req_valid & q_ready;

   // Keep byte i only when it lies below the byte count.
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         byte_keep[i] = (4'(i) < req_valid_bytes);
      end
   end

   always_comb begin
      q_item.first = ~in_msg_ff;
      q_item.last  = req_last_word;
      q_item.len   = req_message_length;
      if (req_valid_bytes >= 4'd8) begin
         q_item.kind = KIND_FULL;
      end else if (req_valid_bytes != 4'd0) begin
         q_item.kind = KIND_PART;
      end else begin
         q_item.kind = KIND_NONE;
      end
      for (int i = 0; i < 8; i++) begin
         q_item.word[8*i +: 8] = byte_keep[i] ? req_data_word[8*i +: 8] : 8'h00;
      end
   end

   always_comb begin
      in_msg_in = in_msg_ff;
      if (q_push) begin
         in_msg_in = ~req_last_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_msg_ff <= 1'b0;
      end else begin
         in_msg_ff <= in_msg_in;
      end
   end

endmodule

@@ rtl/msh_fifo.sv @@
// Short request queue between the front end and the hash engine.
module msh_fifo #(
   parameter int unsigned Depth = msh_pkg::MSH_QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  msh_pkg::msh_item_type push_item,
   output logic                  push_ready,
   input  logic                  pop,
   output logic                  pop_valid,
   output msh_pkg::msh_item_type pop_item
);
   import msh_pkg::*;

   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW = $clog2(Depth + 1);

   msh_item_type    store_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push, do_pop;

   assign push_ready = (count_ff != CntW'(Depth));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = store_ff[rd_ptr_ff];
   assign do_push    = push & push_ready;
   assign do_pop     = pop & pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ rtl/msh_mul.sv @@
// Multiplier by the mix constant modulo 2^64, one 32x32 product per cycle.
module msh_mul (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] operand,
   output logic        done,
   output logic [63:0] result
);
   import msh_pkg::*;

   localparam logic [31:0] MulLo = MIX_MUL[31:0];
   localparam logic [31:0] MulHi = MIX_MUL[63:32];

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic [63:0] x_ff, x_in;
   logic [63:0] prod_ff, prod_in;
   logic [63:0] acc_ff, acc_in;
   logic [31:0] a_op, b_op;

   assign done   = done_ff;
   assign result = acc_ff;

   // Partial products: lo*lo in full, then the two cross terms into the upper half.
   always_comb begin
      case (cnt_ff)
         2'd0: begin
            a_op = x_ff[31:0];
            b_op = MulLo;
         end
         2'd1: begin
            a_op = x_ff[63:32];
            b_op = MulLo;
         end
         2'd2: begin
            a_op = x_ff[31:0];
            b_op = MulHi;
         end
         default: begin
            a_op = x_ff[31:0];
            b_op = MulLo;
         end
      endcase
   end

   assign prod_in = 64'(a_op) * 64'(b_op);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      acc_in  = acc_ff;
      if (start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = 2'd0;
         x_in    = operand;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 2'd1;
         case (cnt_ff)
            2'd0: acc_in = acc_ff;
            2'd1: acc_in = prod_ff;
            2'd2: acc_in = {acc_ff[63:32] + prod_ff[31:0], acc_ff[31:0]};
            2'd3: begin
               acc_in  = {acc_ff[63:32] + prod_ff[31:0], acc_ff[31:0]};
               busy_in = 1'b0;
               done_in = 1'b1;
            end
            default: acc_in = acc_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule

@@ rtl/msh_back.sv @@
// Hash engine: runs the length, mix, fold and finalize steps and holds the result register.
module msh_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  msh_pkg::msh_item_type q_item,
   output logic                  q_pop,
   input  logic                  csr_wr_en,
   input  logic [63:0]           csr_wr_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [63:0]           rsp_hash_value
);
   import msh_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_INIT  = 8'b0000_0010,
      ST_MIXK1 = 8'b0000_0100,
      ST_MIXK2 = 8'b0000_1000,
      ST_FOLD  = 8'b0001_0000,
      ST_PART  = 8'b0010_0000,
      ST_FIN   = 8'b0100_0000,
      ST_OUT   = 8'b1000_0000
   } state_type;

   state_type    state_ff, state_in;
   logic         issued_ff, issued_in;
   msh_item_type cur_ff, cur_in;
   logic [63:0]  h_ff, h_in;
   logic [63:0]  k_ff, k_in;
   logic [63:0]  seed_ff, seed_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [63:0]  rsp_hash_ff, rsp_hash_in;
   logic         mul_state;
   logic         mul_start;
   logic [63:0]  mul_operand;
   logic         mul_done;
   logic [63:0]  mul_result;
   logic [63:0]  h_fin;

   function automatic state_type op_state(kind_type kind, logic last);
      state_type nxt;
      case (kind)
         KIND_FULL: nxt = ST_MIXK1;
         KIND_PART: nxt = ST_PART;
         default:   nxt = last ? ST_FIN : ST_IDLE;
      endcase
      return nxt;
   endfunction

   function automatic state_type end_state(logic last);
      return last ? ST_FIN : ST_IDLE;
   endfunction

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = rsp_hash_ff;
   assign h_fin          = h_ff ^ (h_ff >> MIX_SHIFT);

   assign mul_state = (state_ff == ST_INIT) || (state_ff == ST_MIXK1) ||
                      (state_ff == ST_MIXK2) || (state_ff == ST_FOLD) ||
                      (state_ff == ST_PART) || (state_ff == ST_FIN);
   assign mul_start = mul_state & ~issued_ff;

   always_comb begin
      case (state_ff)
         ST_INIT:  mul_operand = {32'd0, cur_ff.len};
         ST_MIXK1: mul_operand = cur_ff.word;
         ST_MIXK2: mul_operand = k_ff;
         ST_FOLD:  mul_operand = h_ff;
         ST_PART:  mul_operand = h_ff ^ cur_ff.word;
         ST_FIN:   mul_operand = h_fin;
         default:  mul_operand = h_ff;
      endcase
   end

   msh_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .operand (mul_operand),
      .done    (mul_done),
      .result  (mul_result)
   );

   always_comb begin
      state_in     = state_ff;
      issued_in    = issued_ff;
      cur_in       = cur_ff;
      h_in         = h_ff;
      k_in         = k_ff;
      seed_in      = csr_wr_en ? csr_wr_data : seed_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_hash_in  = rsp_hash_ff;
      q_pop        = 1'b0;

      if (mul_start) begin
         issued_in = 1'b1;
      end
      if (mul_state && mul_done) begin
         issued_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               cur_in   = q_item;
               state_in = q_item.first ? ST_INIT : op_state(q_item.kind, q_item.last);
            end
         end
         ST_INIT: begin
            if (mul_done) begin
               h_in     = seed_ff ^ mul_result;
               state_in = op_state(cur_ff.kind, cur_ff.last);
            end
         end
         ST_MIXK1: begin
            if (mul_done) begin
               k_in     = mul_result ^ (mul_result >> MIX_SHIFT);
               state_in = ST_MIXK2;
            end
         end
         ST_MIXK2: begin
            if (mul_done) begin
               h_in     = h_ff ^ mul_result;
               state_in = ST_FOLD;
            end
         end
         ST_FOLD, ST_PART: begin
            if (mul_done) begin
               h_in     = mul_result;
               state_in = end_state(cur_ff.last);
            end
         end
         ST_FIN: begin
            if (mul_done) begin
               h_in     = mul_result;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // Hold until the result register is free.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_hash_in  = h_fin;
               h_in         = h_fin;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      h_ff        <= h_in;
      k_ff        <= k_in;
      rsp_hash_ff <= rsp_hash_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issued_ff    <= 1'b0;
         seed_ff      <= SEED_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issued_ff    <= issued_in;
         seed_ff      <= seed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for the MurmurHash64A stream hash block.
module tb;

   localparam logic [63:0] HASH_MUL = 64'hc6a4a7935bd1e995;
   localparam int unsigned HASH_SHIFT = 47;
   localparam logic [63:0] SEED_AT_RESET = 64'h0000_0000_41C6_4E6D;
   localparam int unsigned SETTLE_CYCLES = 64;
   localparam int unsigned MAX_REPORTS = 10;

   // Tracks the running hash per message and holds the hashes still owed.
   class hash_scoreboard;
      logic [63:0] seed;
      logic [63:0] run_hash;
      bit          in_msg;
      logic [63:0] expected_hashes[$];
      int unsigned mismatches;

      function new();
         seed = SEED_AT_RESET;
         run_hash = '0;
         in_msg = 1'b0;
         mismatches = 0;
      endfunction

      function void set_seed(logic [63:0] value);
         seed = value;
      endfunction

      function int unsigned pending();
         return expected_hashes.size();
      endfunction

      function logic [63:0] mix_word(logic [63:0] k);
         k = k * HASH_MUL;
         k = k ^ (k >> HASH_SHIFT);
         k = k * HASH_MUL;
         return k;
      endfunction

      function void note_request(logic [63:0] word, logic [3:0] nbytes, logic last,
                                 logic [31:0] len);
         logic [63:0] h;
         if (!in_msg) begin
            run_hash = seed ^ (len * HASH_MUL);
            in_msg = 1'b1;
         end
         h = run_hash;
         if (nbytes >= 4'd8) begin
            h = (h ^ mix_word(word)) * HASH_MUL;
         end else if (nbytes != 4'd0) begin
            // drop bytes above the count
            h = (h ^ (word & ((64'd1 << (8 * nbytes)) - 64'd1))) * HASH_MUL;
         end
         if (last) begin
            h = h ^ (h >> HASH_SHIFT);
            h = h * HASH_MUL;
            h = h ^ (h >> HASH_SHIFT);
            expected_hashes.push_back(h);
            in_msg = 1'b0;
         end
         run_hash = h;
      endfunction

      function void check_hash(logic [63:0] actual);
         logic [63:0] want;
         if (expected_hashes.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("hash %h arrived with no message pending", actual);
            return;
         end
         want = expected_hashes.pop_front();
         if (actual !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("hash mismatch: expected %h, got %h", want, actual);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [63:0] req_data_word = '0;
   logic [3:0]  req_valid_bytes = '0;
   logic        req_last_word = 1'b0;
   logic [31:0] req_message_length = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [63:0] rsp_hash_value;
   logic        csr_wr_en = 1'b0;
   logic [63:0] csr_wr_data = '0;

   hash_scoreboard sb;
   int unsigned send_idle_pct = 0;
   int unsigned stall_pct = 0;

   murmur64a_stream_hash_top u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_word      (req_data_word),
      .req_valid_bytes    (req_valid_bytes),
      .req_last_word      (req_last_word),
      .req_message_length (req_message_length),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_hash_value     (rsp_hash_value),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            sb.check_hash(rsp_hash_value);
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Leaves valid high after acceptance so the next request can follow at once.
   task automatic send_request(input logic [63:0] word, input logic [3:0] nbytes,
                               input logic last, input logic [31:0] len);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid          <= 1'b1;
      req_data_word      <= word;
      req_valid_bytes    <= nbytes;
      req_last_word      <= last;
      req_message_length <= len;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(word, nbytes, last, len);
   endtask

   task automatic wait_for_hashes();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // Waits until no hash is still owed, then gives the block time before the next test.
   task automatic settle_block();
      wait_for_hashes();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_seed(input logic [63:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      sb.set_seed(value);
      csr_wr_en <= 1'b0;
   endtask

   task automatic send_message(input int unsigned nbytes, input logic [31:0] stated,
                               output int unsigned n_sent);
      int unsigned remain;
      logic [3:0]  nb;
      remain = nbytes;
      n_sent = 0;
      if (remain == 0) begin
         send_request({$urandom, $urandom}, 4'd0, 1'b1, stated);
         n_sent = 1;
      end
      while (remain > 0) begin
         nb = (remain >= 8) ? 4'd8 : 4'(remain);
         remain -= nb;
         send_request({$urandom, $urandom}, nb, remain == 0, stated);
         n_sent++;
      end
   endtask

   task automatic run_directed();
      send_request('1, 4'd0, 1'b1, 32'd0);
      send_request('0, 4'd8, 1'b1, 32'd8);
      send_request('1, 4'd8, 1'b1, 32'hFFFF_FFFF);
      // oversize counts hash as full words
      send_request(64'h0123_4567_89ab_cdef, 4'd15, 1'b1, 32'd8);
      send_request(64'hfedc_ba98_7654_3210, 4'd9, 1'b1, 32'd8);
      send_request('1, 4'd1, 1'b1, 32'd1);
      send_request('1, 4'd7, 1'b1, 32'd7);
      // partial word before the end, then the message goes on
      send_request(64'h1122_3344_5566_7788, 4'd3, 1'b0, 32'd11);
      send_request(64'h99aa_bbcc_ddee_ff00, 4'd8, 1'b1, 32'd11);
      // empty word in the middle
      send_request(64'hdead_beef_cafe_f00d, 4'd8, 1'b0, 32'd16);
      send_request('1, 4'd0, 1'b0, 32'd16);
      send_request(64'h0f0f_0f0f_f0f0_f0f0, 4'd8, 1'b1, 32'd16);
      // stated length disagrees; length on later words is ignored
      send_request(64'h8000_0000_0000_0001, 4'd8, 1'b0, 32'd100);
      send_request(64'h5555_aaaa_5555_aaaa, 4'd4, 1'b1, 32'd5);
      send_request(64'h0102_0304_0506_0708, 4'd8, 1'b0, 32'd20);
      send_request(64'h1112_1314_1516_1718, 4'd8, 1'b0, 32'd20);
      send_request(64'h2122_2324_2526_2728, 4'd4, 1'b1, 32'd20);
      send_request(64'h3132_3334_3536_3738, 4'd2, 1'b1, 32'd2);
      send_request(64'h4142_4344_4546_4748, 4'd5, 1'b1, 32'd5);
      send_request(64'h5152_5354_5556_5758, 4'd6, 1'b1, 32'd6);
   endtask

   task automatic run_random(input int unsigned n_items);
      int unsigned sent;
      int unsigned pick;
      int unsigned nbytes;
      int unsigned nwords;
      int unsigned n;
      logic [31:0] stated;
      sent = 0;
      while (sent < n_items) begin
         pick = $urandom_range(99);
         if (pick < 15) begin
            // malformed: any count on any word, including early partials
            nwords = $urandom_range(1, 6);
            stated = $urandom;
            for (int i = 0; i < nwords; i++)
               send_request({$urandom, $urandom}, 4'($urandom_range(15)), i == nwords - 1,
                            stated);
            sent += nwords;
         end else begin
            nbytes = (pick < 20) ? $urandom_range(256) : $urandom_range(40);
            stated = ($urandom_range(7) == 0) ? 32'($urandom) : 32'(nbytes);
            send_message(nbytes, stated, n);
            sent += n;
         end
         if ($urandom_range(19) == 0)
            wait_for_hashes();
      end
   endtask

   initial begin
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();
      settle_block();

      write_seed('0);
      run_random(470);
      settle_block();

      write_seed('1);
      send_idle_pct = 65;
      stall_pct = 0;
      run_random(470);
      settle_block();

      write_seed({$urandom, $urandom});
      send_idle_pct = 0;
      stall_pct = 65;
      run_random(470);
      settle_block();

      write_seed({$urandom, $urandom});
      send_idle_pct = 37;
      stall_pct = 37;
      run_random(470);
      settle_block();

      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("murmur64a_stream_hash_top regression: pass");
      else
         $display("murmur64a_stream_hash_top regression: fail");
      $finish;
   end

   initial begin
      #30_000_000;
      $display("murmur64a_stream_hash_top regression: fail");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/msh_pkg.sv
rtl/msh_front.sv
rtl/msh_fifo.sv
rtl/msh_mul.sv
rtl/msh_back.sv
rtl/murmur64a_stream_hash_top.sv
tb/sv/tb.sv
